### src/herm_pkg.sv
package herm_pkg;

  // fixed formats
  localparam int BASIS_FRAC = 16;           // basis weights in Q.16
  localparam int BASIS_W    = 20;           // signed width of one basis weight
  localparam int TAN_FRAC   = 8;            // tangent fraction bits
  localparam int CFG_W      = 16;           // tension / bias width
  localparam int KW         = 17;           // width of 1.0 +- reg
  localparam int SUM_SHIFT  = 8;            // bias sum to 6 fraction bits
  localparam int TAN_SHIFT  = 21 - TAN_FRAC;
  localparam int ACC_SHIFT  = BASIS_FRAC + TAN_FRAC;
  localparam logic signed [KW-1:0] Q14_ONE = 17'sd16384;

  // pipeline layout
  localparam int FRONT_STAGES = 5;          // basis and tangent paths
  localparam int PIPE_DEPTH   = 9;          // front plus combine

  // register map
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic [0:0] {
    REG_TENSION = 1'b0,
    REG_BIAS    = 1'b1
  } herm_reg_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] tension;
    logic signed [CFG_W-1:0] bias;
  } herm_cfg_t;

  typedef logic signed [BASIS_W-1:0] herm_basis_t;

  typedef struct packed {
    herm_basis_t h00;
    herm_basis_t h10;
    herm_basis_t h01;
    herm_basis_t h11;
  } herm_weights_t;

endpackage

### src/herm_in_if.sv
interface herm_in_if #(
  parameter int SAMPLE_BITS   = 16,
  parameter int POSITION_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_before;
  logic signed [SAMPLE_BITS-1:0] sample_start;
  logic signed [SAMPLE_BITS-1:0] sample_end;
  logic signed [SAMPLE_BITS-1:0] sample_after;
  logic [POSITION_BITS-1:0]      position;

  modport source (
    output valid, sample_before, sample_start, sample_end, sample_after, position,
    input  ready
  );
  modport sink (
    input  valid, sample_before, sample_start, sample_end, sample_after, position,
    output ready
  );
endinterface

### src/herm_out_if.sv
interface herm_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          clipped;

  modport source (
    output valid, value, clipped,
    input  ready
  );
  modport sink (
    input  valid, value, clipped,
    output ready
  );
endinterface

### src/hermite_interpolator_top.sv
// Four-point Hermite interpolator with tension and bias.
//
// samples: one word per interpolated point, carrying the four neighbor
//   samples around the interval and the fractional position mu (Q0.P).
// result: one word per input word, the interpolated sample saturated to
//   the sample width, with clipped set when saturation took place.
// APB port: tension at 0x0, bias at 0x4, both signed Q1.14, reset to 0.
//   Write them only while nothing is in flight.
//
// Throughput: one word per cycle while result.ready stays high. Path from
// acceptance to result.valid: nine pipe stages plus the output register.
// The depth is set by the chain mu^2 -> mu^3 -> weights on one side and
// bias sum -> tension product -> rounding on the other, each product
// registered, followed by the four weight products, the sum and the clamp.
//
// Reset clears all valid bits and the registers; the datapath is not reset.
// When result.ready drops, the word in flight lands in a one-word skid
// register and samples.ready falls the next cycle; the whole pipe then
// holds until the skid drains. Nothing is dropped or repeated.
module hermite_interpolator_top #(
  parameter int SAMPLE_BITS   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  herm_in_if.sink     samples,
  herm_out_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import herm_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  herm_cfg_t             cfg;
  herm_weights_t         weights;
  logic signed [SB+14:0] m0, m1;
  logic signed [SB-1:0]  y1_d, y2_d;
  logic signed [SB-1:0]  pipe_value;
  logic                  pipe_clipped;

  // one valid bit per stage, shifted with the data
  logic [PIPE_DEPTH-1:0] vld;
  logic                  advance;

  // output register and skid word
  logic                  out_valid;
  logic signed [SB-1:0]  out_value;
  logic                  out_clipped;
  logic                  skid_valid;
  logic signed [SB-1:0]  skid_value;
  logic                  skid_clipped;

  herm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  herm_basis #(.POSITION_BITS(POSITION_BITS)) u_basis (
    .clk      (clk),
    .advance  (advance),
    .position (samples.position),
    .weights  (weights)
  );

  herm_tangent #(.SAMPLE_BITS(SAMPLE_BITS)) u_tangent (
    .clk     (clk),
    .advance (advance),
    .cfg     (cfg),
    .y0      (samples.sample_before),
    .y1      (samples.sample_start),
    .y2      (samples.sample_end),
    .y3      (samples.sample_after),
    .m0      (m0),
    .m1      (m1),
    .y1_d    (y1_d),
    .y2_d    (y2_d)
  );

  herm_combine #(.SAMPLE_BITS(SAMPLE_BITS)) u_combine (
    .clk     (clk),
    .advance (advance),
    .weights (weights),
    .m0      (m0),
    .m1      (m1),
    .y1      (y1_d),
    .y2      (y2_d),
    .value   (pipe_value),
    .clipped (pipe_clipped)
  );

  // pipe moves whenever the skid word is free
  assign advance       = !skid_valid;
  assign samples.ready = advance;

  assign result.valid   = out_valid;
  assign result.value   = out_value;
  assign result.clipped = out_clipped;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[PIPE_DEPTH-2:0], samples.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_valid   <= 1'b1;
        out_value   <= skid_value;
        out_clipped <= skid_clipped;
        skid_valid  <= 1'b0;
      end else begin
        out_valid   <= vld[PIPE_DEPTH-1];
        out_value   <= pipe_value;
        out_clipped <= pipe_clipped;
      end
    end else if (vld[PIPE_DEPTH-1] && !skid_valid) begin
      // receiver stalled: park the word leaving the pipe
      skid_valid   <= 1'b1;
      skid_value   <= pipe_value;
      skid_clipped <= pipe_clipped;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held while output register is empty");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> vld[0])
    else $error("accepted word missing from first stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(vld))
    else $error("pipe valid bits moved during stall");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_clipped) |-> (out_value == S_MAX || out_value == S_MIN))
    else $error("clipped word not at a rail");

endmodule

### src/herm_cfg.sv
module herm_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [herm_pkg::ADDR_W-1:0]   paddr,
  input  logic [herm_pkg::DATA_W-1:0]   pwdata,
  output logic [herm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output herm_pkg::herm_cfg_t           cfg
);
  import herm_pkg::*;

  herm_reg_t reg_sel;
  logic      wr_en;

  assign reg_sel = herm_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tension <= '0;
      cfg.bias    <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TENSION: cfg.tension <= pwdata[CFG_W-1:0];
        REG_BIAS:    cfg.bias    <= pwdata[CFG_W-1:0];
        default:     cfg.bias    <= cfg.bias;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TENSION: prdata = {{(DATA_W-CFG_W){1'b0}}, cfg.tension};
      REG_BIAS:    prdata = {{(DATA_W-CFG_W){1'b0}}, cfg.bias};
      default:     prdata = '0;
    endcase
  end

endmodule

### src/herm_basis.sv
module herm_basis #(
  parameter int POSITION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      advance,
  input  logic [POSITION_BITS-1:0]  position,
  output herm_pkg::herm_weights_t   weights
);
  import herm_pkg::*;

  localparam int PB     = POSITION_BITS;
  localparam int PPW    = 2 * PB;
  localparam int HQW    = PB + 4;
  localparam int BSH_R  = (PB >= BASIS_FRAC) ? PB - BASIS_FRAC : 0;
  localparam int BSH_L  = (PB >= BASIS_FRAC) ? 0 : BASIS_FRAC - PB;
  localparam int HX     = HQW + BSH_L + 1;
  localparam int BR_HALF = (1 << BSH_R) >> 1;
  localparam logic [PPW-1:0] HALF_P = PPW'(1) << (PB - 1);
  localparam logic signed [HQW-1:0] ONE_Q = HQW'(1) << PB;

  // stage 1..4: powers of mu
  logic [PPW-1:0] pp1, mu3p3;
  logic [PB-1:0]  p1, p2, p3, p4, mu2_2, mu2_3, mu2_4, mu3_4;
  logic [PPW-1:0] mu2_rnd, mu3_rnd;

  // stage 5: weights
  logic signed [HQW-1:0] m2s, m3s, ps;
  logic signed [HQW-1:0] hq [4];
  logic signed [HX-1:0]  hr [4];
  herm_basis_t           hb [4];

  assign mu2_rnd = pp1 + HALF_P;
  assign mu3_rnd = mu3p3 + HALF_P;

  always_comb begin
    m2s = signed'(HQW'(mu2_4));
    m3s = signed'(HQW'(mu3_4));
    ps  = signed'(HQW'(p4));
    hq[0] = (m3s <<< 1) - ((m2s <<< 1) + m2s) + ONE_Q;
    hq[1] = m3s - (m2s <<< 1) + ps;
    hq[2] = m3s - m2s;
    hq[3] = ((m2s <<< 1) + m2s) - (m3s <<< 1);
    for (int i = 0; i < 4; i++) begin
      hr[i] = ((HX'(hq[i]) + HX'(BR_HALF)) >>> BSH_R) <<< BSH_L;
      hb[i] = hr[i][BASIS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pp1   <= PPW'(position) * PPW'(position);
      p1    <= position;
      mu2_2 <= mu2_rnd[PPW-1:PB];
      p2    <= p1;
      mu3p3 <= PPW'(mu2_2) * PPW'(p2);
      mu2_3 <= mu2_2;
      p3    <= p2;
      mu3_4 <= mu3_rnd[PPW-1:PB];
      mu2_4 <= mu2_3;
      p4    <= p3;
      weights.h00 <= hb[0];
      weights.h10 <= hb[1];
      weights.h01 <= hb[2];
      weights.h11 <= hb[3];
    end
  end

endmodule

### src/herm_tangent.sv
module herm_tangent #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           advance,
  input  herm_pkg::herm_cfg_t            cfg,
  input  logic signed [SAMPLE_BITS-1:0]  y0,
  input  logic signed [SAMPLE_BITS-1:0]  y1,
  input  logic signed [SAMPLE_BITS-1:0]  y2,
  input  logic signed [SAMPLE_BITS-1:0]  y3,
  output logic signed [SAMPLE_BITS+14:0] m0,
  output logic signed [SAMPLE_BITS+14:0] m1,
  output logic signed [SAMPLE_BITS-1:0]  y1_d,
  output logic signed [SAMPLE_BITS-1:0]  y2_d
);
  import herm_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int DW  = SB + 1;
  localparam int PW  = DW + KW;
  localparam int SW  = PW + 1;
  localparam int S6W = SW - SUM_SHIFT;
  localparam int QW  = S6W + KW;
  localparam int MW  = QW - TAN_SHIFT;

  logic signed [KW-1:0] kp, km, kt;
  logic signed [DW-1:0] d0, d1, d2;
  logic signed [PW-1:0] pa0, pb0, pa1, pb1;
  logic signed [SW-1:0] sum0, sum1;
  logic signed [S6W-1:0] s0, s1;
  logic signed [QW-1:0] q0, q1, qr0, qr1;
  logic signed [MW-1:0] m0_4, m1_4;
  logic signed [SB-1:0] y1_dl [FRONT_STAGES];
  logic signed [SB-1:0] y2_dl [FRONT_STAGES];

  assign kp = Q14_ONE + KW'(cfg.bias);
  assign km = Q14_ONE - KW'(cfg.bias);
  assign kt = Q14_ONE - KW'(cfg.tension);

  assign d0 = DW'(y1) - DW'(y0);
  assign d1 = DW'(y2) - DW'(y1);
  assign d2 = DW'(y3) - DW'(y2);

  assign sum0 = SW'(pa0) + SW'(pb0) + SW'(1 << (SUM_SHIFT - 1));
  assign sum1 = SW'(pa1) + SW'(pb1) + SW'(1 << (SUM_SHIFT - 1));
  assign qr0  = q0 + QW'(1 << (TAN_SHIFT - 1));
  assign qr1  = q1 + QW'(1 << (TAN_SHIFT - 1));

  assign y1_d = y1_dl[FRONT_STAGES-1];
  assign y2_d = y2_dl[FRONT_STAGES-1];

  always_ff @(posedge clk) begin
    if (advance) begin
      // 1: weighted differences
      pa0  <= PW'(d0) * PW'(kp);
      pb0  <= PW'(d1) * PW'(km);
      pa1  <= PW'(d1) * PW'(kp);
      pb1  <= PW'(d2) * PW'(km);
      // 2: bias sum, rounded
      s0   <= sum0[SW-1:SUM_SHIFT];
      s1   <= sum1[SW-1:SUM_SHIFT];
      // 3: tension scale
      q0   <= QW'(s0) * QW'(kt);
      q1   <= QW'(s1) * QW'(kt);
      // 4: round to tangent format
      m0_4 <= qr0[QW-1:TAN_SHIFT];
      m1_4 <= qr1[QW-1:TAN_SHIFT];
      // 5: align with basis path
      m0   <= m0_4;
      m1   <= m1_4;
      y1_dl[0] <= y1;
      y2_dl[0] <= y2;
      for (int i = 1; i < FRONT_STAGES; i++) begin
        y1_dl[i] <= y1_dl[i-1];
        y2_dl[i] <= y2_dl[i-1];
      end
    end
  end

endmodule

### src/herm_combine.sv
module herm_combine #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           advance,
  input  herm_pkg::herm_weights_t        weights,
  input  logic signed [SAMPLE_BITS+14:0] m0,
  input  logic signed [SAMPLE_BITS+14:0] m1,
  input  logic signed [SAMPLE_BITS-1:0]  y1,
  input  logic signed [SAMPLE_BITS-1:0]  y2,
  output logic signed [SAMPLE_BITS-1:0]  value,
  output logic                           clipped
);
  import herm_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int MW  = SB + 15;
  localparam int TYW = BASIS_W + SB;
  localparam int TMW = BASIS_W + MW;
  localparam int SAW = TYW + 1;
  localparam int SBW = TMW + 1;
  localparam int AW  = SBW + 1;
  localparam int RW  = AW - ACC_SHIFT;
  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  logic signed [TYW-1:0] t0, t3;
  logic signed [TMW-1:0] t1, t2;
  logic signed [SAW-1:0] sa;
  logic signed [SBW-1:0] sb;
  logic signed [AW-1:0]  acc;
  logic signed [RW-1:0]  r;

  assign acc = (AW'(sa) <<< TAN_FRAC) + AW'(sb) + AW'(1 << (ACC_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (advance) begin
      t0 <= TYW'(weights.h00) * TYW'(y1);
      t3 <= TYW'(weights.h11) * TYW'(y2);
      t1 <= TMW'(weights.h10) * TMW'(m0);
      t2 <= TMW'(weights.h01) * TMW'(m1);
      sa <= SAW'(t0) + SAW'(t3);
      sb <= SBW'(t1) + SBW'(t2);
      r  <= acc[AW-1:ACC_SHIFT];
      priority if (r > RW'(S_MAX)) begin
        value   <= S_MAX;
        clipped <= 1'b1;
      end else if (r < RW'(S_MIN)) begin
        value   <= S_MIN;
        clipped <= 1'b1;
      end else begin
        value   <= r[SB-1:0];
        clipped <= 1'b0;
      end
    end
  end

endmodule

### dv/hermite_interpolator_top_test.sv
`timescale 1ns / 1ps

// Testbench for the four-point Hermite interpolator.
// Samples words go in, one result word comes back per samples word.
// A scoreboard class recomputes every point in fixed point and compares
// the results in order. Tension and bias change between phases, and the
// handshakes are throttled at rates taken from a plan for each phase.
module hermite_interpolator_top_test;
  import herm_pkg::*;

  localparam int SW         = 16;      // sample width
  localparam int PW         = 16;      // position width (Q0.16)
  localparam int NUM_PHASES = 11;
  localparam int PHASE_LEN  = 105;     // random words per phase
  localparam int PRESS_PH   = 4;       // phase with the long output hold
  localparam int HOLD_LEN   = 150;     // output hold length, in cycles
  localparam int TAIL_WAIT  = 20;      // extra wait after the last expected result
  localparam int CYCLE_MAX  = 400000;  // far above the slowest correct run
  localparam int PRINT_CAP  = 100;

  // One samples word: four neighbors and the fractional position.
  typedef struct packed {
    logic signed [SW-1:0] s_prev;
    logic signed [SW-1:0] s_start;
    logic signed [SW-1:0] s_stop;
    logic signed [SW-1:0] s_next;
    logic [PW-1:0]        mu;
  } interp_word_t;

  // One result word.
  typedef struct packed {
    logic signed [SW-1:0] value;
    logic                 clipped;
  } interp_out_t;

  // Fixed-point Hermite predictor plus the queue of points still owed by the block.
  class hermite_check;
    longint      tension_val;
    longint      bias_val;
    interp_out_t expected_points[$];
    int          mismatches;
    int          results_seen;
    int          clip_count;

    function new();
      tension_val  = 0;
      bias_val     = 0;
      mismatches   = 0;
      results_seen = 0;
      clip_count   = 0;
    endfunction

    function void set_reg(herm_reg_t idx, logic [15:0] v);
      if (idx == REG_TENSION)
        tension_val = longint'(signed'(v));
      else
        bias_val = longint'(signed'(v));
    endfunction

    // round half up, then divide by 2^sh
    function longint half_up(longint x, int sh);
      return (x + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    // tangent in Q.8: bias-weighted slope sum, cut to Q.6, times (1 - tension)
    function longint tangent_q8(longint d_a, longint d_b);
      longint mix;
      longint mix6;
      mix  = d_a * (64'sd16384 + bias_val) + d_b * (64'sd16384 - bias_val);
      mix6 = half_up(mix, 8);
      return half_up(mix6 * (64'sd16384 - tension_val), 13);
    endfunction

    function interp_out_t interpolate(interp_word_t w);
      longint y0, y1, y2, y3, mu, mu_sq, mu_cu;
      longint h00, h10, h01, h11, m0, m1, acc, r;
      interp_out_t o;
      y0    = longint'(w.s_prev);
      y1    = longint'(w.s_start);
      y2    = longint'(w.s_stop);
      y3    = longint'(w.s_next);
      mu    = longint'(w.mu);
      mu_sq = half_up(mu * mu, PW);
      mu_cu = half_up(mu_sq * mu, PW);
      // basis already in Q.16 since the position is Q0.16
      h00   = 2 * mu_cu - 3 * mu_sq + 64'sd65536;
      h10   = mu_cu - 2 * mu_sq + mu;
      h01   = mu_cu - mu_sq;
      h11   = 3 * mu_sq - 2 * mu_cu;
      m0    = tangent_q8(y1 - y0, y2 - y1);
      m1    = tangent_q8(y2 - y1, y3 - y2);
      acc   = h00 * y1 * 256 + h10 * m0 + h01 * m1 + h11 * y2 * 256;
      r     = half_up(acc, 24);
      o.clipped = 1'b0;
      if (r > 32767) begin
        r = 32767;
        o.clipped = 1'b1;
      end else if (r < -32768) begin
        r = -32768;
        o.clipped = 1'b1;
      end
      o.value = r[SW-1:0];
      return o;
    endfunction

    function void note_input(interp_word_t w);
      expected_points.push_back(interpolate(w));
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_result(logic signed [SW-1:0] got_value, logic got_clip);
      interp_out_t want;
      results_seen++;
      if (expected_points.size() == 0) begin
        report($sformatf("result word %0d/%0b arrived with nothing expected",
                         got_value, got_clip));
      end else begin
        want = expected_points.pop_front();
        if (want.clipped)
          clip_count++;
        if (got_value !== want.value)
          report($sformatf("value %0d, expected %0d", got_value, want.value));
        if (got_clip !== want.clipped)
          report($sformatf("clipped %0b, expected %0b", got_clip, want.clipped));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  herm_in_if  #(.SAMPLE_BITS(SW), .POSITION_BITS(PW)) samples_if ();
  herm_out_if #(.SAMPLE_BITS(SW))                     result_if ();

  hermite_interpolator_top #(
    .SAMPLE_BITS  (SW),
    .POSITION_BITS(PW)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_if),
    .result (result_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  hermite_check sb;

  int   src_idle_pct;     // only the stimulus process touches this
  int   sink_stall_pct;   // set with NBAs, read by the receiver
  logic hold_armed;
  logic hold_fired;
  int   hold_left;
  int   cycles;
  int   input_stalls;
  int   words_sent;
  int   phases_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Global watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Cycles where the block turned a valid samples word away.
  always @(posedge clk) begin
    if (!rst && samples_if.valid && !samples_if.ready)
      input_stalls++;
  end

  // Long output hold, counted here on its own. Armed once by the stimulus,
  // it holds result.ready low while hold_left counts down from HOLD_LEN and
  // words keep coming, so the pipe and skid fill up and samples.ready has to fall.
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_fired <= 1'b0;
    end else if (hold_armed && !hold_fired) begin
      hold_left  <= HOLD_LEN;
      hold_fired <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: check every accepted result word, then pick ready for the
  // next cycle from the stall rate of the phase and the hold above.
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready)
        sb.check_result(result_if.value, result_if.clipped);
      result_if.ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // APB setup and access. psel is left high at the end so that back-to-back
  // transfers never assign it twice in one step; bus_idle closes the burst.
  task automatic reg_write(herm_reg_t idx, logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{16{v[15]}}, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
  endtask

  task automatic reg_readback(herm_reg_t idx, logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // prdata is sampled at the completing edge, before anything updates
    if (prdata[15:0] !== v)
      sb.report($sformatf("register %s reads %h, expected %h", idx.name(),
                          prdata[15:0], v));
  endtask

  task automatic bus_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one samples word. An idle gap, when drawn, drops valid first;
  // otherwise valid stays high straight from the previous word.
  task automatic send_word(interp_word_t w);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < src_idle_pct)
      gap++;
    if (gap != 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid         <= 1'b1;
    samples_if.sample_before <= w.s_prev;
    samples_if.sample_start  <= w.s_start;
    samples_if.sample_end    <= w.s_stop;
    samples_if.sample_after  <= w.s_next;
    samples_if.position      <= w.mu;
    do @(posedge clk); while (!samples_if.ready);
    sb.note_input(w);
    words_sent++;
  endtask

  function automatic interp_word_t word_of(int a, int b, int c, int d, int m);
    interp_word_t w;
    w.s_prev  = a[SW-1:0];
    w.s_start = b[SW-1:0];
    w.s_stop  = c[SW-1:0];
    w.s_next  = d[SW-1:0];
    w.mu      = m[PW-1:0];
    return w;
  endfunction

  function automatic int clamp16(int x);
    if (x > 32767)
      return 32767;
    if (x < -32768)
      return -32768;
    return x;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(3))
      0:       return 32767;
      1:       return -32768;
      2:       return 0;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // Mix of shapes: plain noise, smooth ramps like real audio, extremes,
  // and large swings that overshoot and clip.
  function automatic interp_word_t random_word();
    int kind, base, step, sgn, m;
    interp_word_t w;
    kind = $urandom_range(9);
    m    = $urandom_range(65535);
    if ($urandom_range(15) == 0) begin
      case ($urandom_range(3))
        0:       m = 0;
        1:       m = 1;
        2:       m = 32768;
        default: m = 65535;
      endcase
    end
    if (kind <= 3) begin
      w = word_of($urandom_range(65535), $urandom_range(65535),
                  $urandom_range(65535), $urandom_range(65535), m);
    end else if (kind <= 6) begin
      base = int'($urandom_range(65535)) - 32768;
      step = int'($urandom_range(8192)) - 4096;
      w = word_of(clamp16(base), clamp16(base + step + int'($urandom_range(64)) - 32),
                  clamp16(base + 2 * step + int'($urandom_range(64)) - 32),
                  clamp16(base + 3 * step), m);
    end else if (kind == 7) begin
      w = word_of(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(), m);
    end else begin
      // peak or trough in the middle two samples
      sgn  = $urandom_range(1) ? 1 : -1;
      base = 24000 + int'($urandom_range(8767));
      w = word_of(-sgn * base, sgn * base, sgn * (base - int'($urandom_range(2000))),
                  -sgn * int'($urandom_range(32767)), m);
    end
    return w;
  endfunction

  initial begin
    logic [15:0] t_plan [NUM_PHASES];
    logic [15:0] b_plan [NUM_PHASES];
    int          src_plan [NUM_PHASES];
    int          sink_plan [NUM_PHASES];
    logic [15:0] t_now;
    logic [15:0] b_now;
    int          ph;
    int          n;

    // Settings walk through neutral, the +-1.0 limits and values beyond
    // them; phases 7 to 9 draw random settings.
    t_plan    = '{16'h0000, 16'h4000, 16'hC000, 16'h2000, 16'h8000, 16'h7FFF,
                  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hE000};
    b_plan    = '{16'h0000, 16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000,
                  16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h1000};
    src_plan  = '{0, 60, 0, 35, 0, 35, 60, 0, 35, 0, 35};
    sink_plan = '{0, 0, 60, 35, 0, 35, 0, 60, 35, 0, 35};

    sb                       = new();
    rst                      = 1'b1;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    samples_if.valid         = 1'b0;
    samples_if.sample_before = '0;
    samples_if.sample_start  = '0;
    samples_if.sample_end    = '0;
    samples_if.sample_after  = '0;
    samples_if.position      = '0;
    src_idle_pct             = 0;
    sink_stall_pct           = 0;
    hold_armed               = 1'b0;
    words_sent               = 0;
    phases_done              = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset values first
    reg_readback(REG_TENSION, 16'h0000);
    reg_readback(REG_BIAS, 16'h0000);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // registers change only with nothing in flight
      while (sb.pending() != 0)
        @(posedge clk);
      t_now = t_plan[ph];
      b_now = b_plan[ph];
      if (ph >= 7 && ph <= 9) begin
        t_now = 16'($urandom_range(65535));
        b_now = 16'($urandom_range(65535));
      end
      reg_write(REG_TENSION, t_now);
      reg_write(REG_BIAS, b_now);
      reg_readback(REG_TENSION, t_now);
      reg_readback(REG_BIAS, b_now);
      bus_idle();
      src_idle_pct   = src_plan[ph];
      sink_stall_pct <= sink_plan[ph];
      if (ph == PRESS_PH)
        hold_armed <= 1'b1;

      if (ph == 0) begin
        // zero input, all positions at the corners
        send_word(word_of(0, 0, 0, 0, 0));
        send_word(word_of(0, 0, 0, 0, 65535));
        // flat lines at both rails: no clipping expected
        send_word(word_of(32767, 32767, 32767, 32767, 32768));
        send_word(word_of(-32768, -32768, -32768, -32768, 32768));
        send_word(word_of(32767, 32767, 32767, 32767, 65535));
        // mu = 0 gives the start sample, mu near 1 nearly the end sample
        send_word(word_of(100, -2000, 3000, 7, 0));
        send_word(word_of(100, -2000, 3000, 7, 1));
        send_word(word_of(100, -2000, 3000, 7, 65535));
        // steepest ramps across the full range
        send_word(word_of(-32768, -32768, 32767, 32767, 32768));
        send_word(word_of(32767, 32767, -32768, -32768, 16384));
        // peak between rails overshoots high; trough overshoots low
        send_word(word_of(-32768, 32767, 32767, -32768, 32768));
        send_word(word_of(32767, -32768, -32768, 32767, 32768));
        send_word(word_of(-32768, 32767, 32000, -32768, 20000));
        send_word(word_of(32767, -32768, -32000, 32767, 45000));
        // zigzag, every bit of every sample toggling
        send_word(word_of(16'h5555, 16'hAAAA - 65536, 16'h5555, 16'hAAAA - 65536,
                          16'hAAAA));
        send_word(word_of(16'hAAAA - 65536, 16'h5555, 16'hAAAA - 65536, 16'h5555,
                          16'h5555));
        // small values near zero with rounding at the half LSB
        send_word(word_of(-1, 0, 1, 0, 32768));
        send_word(word_of(1, 0, -1, 0, 49152));
      end

      for (n = 0; n < PHASE_LEN; n++)
        send_word(random_word());
      samples_if.valid <= 1'b0;
      phases_done++;
    end

    while (sb.pending() != 0)
      @(posedge clk);
    // anything extra the block emits after the last point shows up here
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Covered %0d samples words over %0d tension/bias settings, %0d results clipped.",
             words_sent, phases_done, sb.clip_count);
    $display("Input stalled on %0d cycles; %0d result words checked.",
             input_stalls, sb.results_seen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/herm_pkg.sv
src/herm_in_if.sv
src/herm_out_if.sv
src/herm_cfg.sv
src/herm_basis.sv
src/herm_tangent.sv
src/herm_combine.sv
src/hermite_interpolator_top.sv
dv/hermite_interpolator_top_test.sv
